FILE: hw/rtl/siocfg_pkg.sv
// shared constants and types for the super i/o configuration decoder
package siocfg_pkg;

   // register file size
   localparam int REG_COUNT_DEFAULT = 256;

   // access kinds and port selects
   localparam logic MODE_READ  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;
   localparam logic PORT_INDEX = 1'b0;
   localparam logic PORT_DATA  = 1'b1;

   // configuration register indexes
   localparam logic [7:0] IDX_MIN_READABLE = 8'hBC;
   localparam logic [7:0] REG_LPT_CTRL     = 8'hBE;
   localparam logic [7:0] REG_LPT_BASE     = 8'hBF;
   localparam logic [7:0] REG_SER_CTRL     = 8'hDB;
   localparam logic [7:0] REG_COM1_BASE    = 8'hDC;
   localparam logic [7:0] REG_COM2_BASE    = 8'hDD;
   localparam logic [7:0] REG_SER_IRQ      = 8'hDE;
   localparam logic [7:0] REG_FDD_CTRL     = 8'hFB;
   localparam logic [7:0] REG_IDE_CTRL     = 8'hFE;

   // bit masks inside those registers
   localparam logic [7:0] LPT_DIS_MASK   = 8'h18;
   localparam logic [7:0] SER1_DIS_MASK  = 8'h18;
   localparam logic [7:0] SER2_DIS_MASK  = 8'h03;
   localparam logic [7:0] SER_IRQ_MASK   = 8'hF0;
   localparam logic [7:0] FDD_DIS_BIT    = 8'h02;
   localparam logic [7:0] IDE_DIS_BIT    = 8'h02;
   localparam logic [7:0] READ_BLOCKED   = 8'hFF;

   // irq numbers
   localparam logic [2:0] IRQ_NONE = 3'd0;
   localparam logic [2:0] IRQ_3    = 3'd3;
   localparam logic [2:0] IRQ_4    = 3'd4;
   localparam logic [2:0] IRQ_5    = 3'd5;

   // power-up mappings
   localparam logic [9:0] LPT_BASE_RESET  = 10'h378;
   localparam logic [9:0] COM1_BASE_RESET = 10'h3F8;
   localparam logic [9:0] COM2_BASE_RESET = 10'h2F8;
   localparam logic [2:0] SER1_IRQ_RESET  = IRQ_4;
   localparam logic [2:0] SER2_IRQ_RESET  = IRQ_3;

   // register file access requests
   typedef struct packed {
      logic       en;
      logic [7:0] addr;
   } rf_rd_type;

   typedef struct packed {
      logic       en;
      logic [7:0] addr;
      logic [7:0] data;
   } rf_wr_type;

endpackage

FILE: hw/rtl/siocfg_req_if.sv
// bus access channel into the decoder
interface siocfg_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic       port_select;
   logic [7:0] write_data;

   modport source (output valid, output mode, output port_select, output write_data,
                   input ready);
   modport sink (input valid, input mode, input port_select, input write_data,
                 output ready);
endinterface

FILE: hw/rtl/siocfg_rsp_if.sv
// result channel out of the decoder
interface siocfg_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       lpt_enabled;
   logic [9:0] lpt_base;
   logic       com1_enabled;
   logic [9:0] com1_base;
   logic [2:0] ser1_irq;
   logic       com2_enabled;
   logic [9:0] com2_base;
   logic [2:0] ser2_irq;
   logic       floppy_enabled;
   logic       ide_enabled;

   modport source (output valid, output read_data, output lpt_enabled, output lpt_base,
                   output com1_enabled, output com1_base, output ser1_irq,
                   output com2_enabled, output com2_base, output ser2_irq,
                   output floppy_enabled, output ide_enabled, input ready);
   modport sink (input valid, input read_data, input lpt_enabled, input lpt_base,
                 input com1_enabled, input com1_base, input ser1_irq,
                 input com2_enabled, input com2_base, input ser2_irq,
                 input floppy_enabled, input ide_enabled, output ready);
endinterface

FILE: hw/rtl/siocfg_regfile.sv
// configuration byte store: one registered read port, one write port, written flags
module siocfg_regfile
   import siocfg_pkg::*;
#(
   parameter int REGISTER_COUNT = REG_COUNT_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  rf_rd_type  rd_req,
   output logic [7:0] rd_data,
   input  rf_wr_type  wr_req
);

   localparam int AW = $clog2(REGISTER_COUNT);

   logic [7:0]                mem [REGISTER_COUNT];
   logic [REGISTER_COUNT-1:0] written_ff;
   logic [7:0]                rd_data_ff;
   logic                      rd_written_ff;

   // storage array, registered read
   always_ff @(posedge clock) begin
      if (rd_req.en) begin
         rd_data_ff <= mem[rd_req.addr[AW-1:0]];
      end
      if (wr_req.en) begin
         mem[wr_req.addr[AW-1:0]] <= wr_req.data;
      end
   end

   // per-entry written flags, an unwritten entry reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         if (wr_req.en) begin
            written_ff[wr_req.addr[AW-1:0]] <= 1'b1;
         end
         if (rd_req.en) begin
            rd_written_ff <= written_ff[rd_req.addr[AW-1:0]];
         end
      end
   end

   assign rd_data = rd_written_ff ? rd_data_ff : 8'h00;

endmodule

FILE: hw/rtl/superio_config_register_decoder_core.sv
// top level of the super i/o index/data configuration decoder
//
//   channel | dir | handshake             | carries
//   req_bus | in  | valid/ready           | mode, port_select, write_data
//   rsp_bus | out | valid/ready           | read_data and the current device mappings
//
// an item is worked in order: the accept edge reads the register file at the current
// index, the commit edge does the read-modify-write and loads the result register.
// ready is low in execute, so a new item is taken only after the last one commits.
// reset is synchronous; written flags make the register file read as zero, no clear pass.
// a waiting result does not block acceptance; the next item holds in execute until
// the result register frees up.
module superio_config_register_decoder_core
   import siocfg_pkg::*;
#(
   parameter int REGISTER_COUNT = REG_COUNT_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   siocfg_req_if.sink   req_bus,
   siocfg_rsp_if.source rsp_bus
);

   typedef enum logic {ST_IDLE, ST_EXEC} state_type;

   state_type  state_ff, state_in;
   logic       mode_ff, port_ff;
   logic [7:0] wdata_ff;
   logic [7:0] index_ff, index_in;

   // shadows of the registers that feed the mappings
   logic [7:0] lpt_ctrl_ff, lpt_ctrl_in;
   logic [7:0] lpt_basereg_ff, lpt_basereg_in;
   logic [7:0] ser_ctrl_ff, ser_ctrl_in;
   logic [7:0] com1_basereg_ff, com1_basereg_in;
   logic [7:0] com2_basereg_ff, com2_basereg_in;
   logic [7:0] ser_irq_ff, ser_irq_in;

   // device mappings
   logic       lpt_en_ff, lpt_en_in;
   logic [9:0] lpt_base_ff, lpt_base_in;
   logic       com1_en_ff, com1_en_in;
   logic [9:0] com1_base_ff, com1_base_in;
   logic [2:0] ser1_irq_ff, ser1_irq_in;
   logic       com2_en_ff, com2_en_in;
   logic [9:0] com2_base_ff, com2_base_in;
   logic [2:0] ser2_irq_ff, ser2_irq_in;
   logic       floppy_ff, floppy_in;
   logic       ide_ff, ide_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;

   logic       accept, commit, is_data_wr;
   logic [7:0] old_byte, diff;
   logic       lpt_trig, com1_trig, com2_trig;
   logic [2:0] ser1_irq_new, ser2_irq_new;
   rf_rd_type  rd_req;
   rf_wr_type  wr_req;

   // register file
   siocfg_regfile #(
      .REGISTER_COUNT(REGISTER_COUNT)
   ) u_regfile (
      .clock  (clock),
      .reset  (reset),
      .rd_req (rd_req),
      .rd_data(old_byte),
      .wr_req (wr_req)
   );

   // handshake and register file access
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign commit        = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_bus.ready);
   assign is_data_wr    = (mode_ff == MODE_WRITE) && (port_ff == PORT_DATA);
   assign diff          = old_byte ^ wdata_ff;

   assign rd_req.en   = accept;
   assign rd_req.addr = index_ff;
   assign wr_req.en   = commit && is_data_wr;
   assign wr_req.addr = index_ff;
   assign wr_req.data = wdata_ff;

   // shadow register update
   always_comb begin
      lpt_ctrl_in     = lpt_ctrl_ff;
      lpt_basereg_in  = lpt_basereg_ff;
      ser_ctrl_in     = ser_ctrl_ff;
      com1_basereg_in = com1_basereg_ff;
      com2_basereg_in = com2_basereg_ff;
      ser_irq_in      = ser_irq_ff;
      if (is_data_wr) begin
         case (index_ff)
            REG_LPT_CTRL:  lpt_ctrl_in     = wdata_ff;
            REG_LPT_BASE:  lpt_basereg_in  = wdata_ff;
            REG_SER_CTRL:  ser_ctrl_in     = wdata_ff;
            REG_COM1_BASE: com1_basereg_in = wdata_ff;
            REG_COM2_BASE: com2_basereg_in = wdata_ff;
            REG_SER_IRQ:   ser_irq_in      = wdata_ff;
            default: ;
         endcase
      end
   end

   // which mappings get derived again
   always_comb begin
      lpt_trig  = is_data_wr &&
                  (((index_ff == REG_LPT_CTRL) && |(diff & LPT_DIS_MASK)) ||
                   ((index_ff == REG_LPT_BASE) && |diff));
      com1_trig = is_data_wr &&
                  (((index_ff == REG_SER_CTRL) && |(diff & SER1_DIS_MASK)) ||
                   ((index_ff == REG_COM1_BASE) && |diff) ||
                   ((index_ff == REG_SER_IRQ) && |(diff & SER_IRQ_MASK)));
      com2_trig = is_data_wr &&
                  (((index_ff == REG_SER_CTRL) && |(diff & SER2_DIS_MASK)) ||
                   ((index_ff == REG_COM2_BASE) && |diff) ||
                   ((index_ff == REG_SER_IRQ) && |(diff & SER_IRQ_MASK)));
   end

   // serial irq source selection
   always_comb begin
      ser1_irq_new = IRQ_NONE;
      if ((ser_ctrl_in & SER1_DIS_MASK) == 8'h00) begin
         if (ser_irq_in[7:6] == 2'b10) begin
            ser1_irq_new = IRQ_3;
         end else if (ser_irq_in[5:4] == 2'b10) begin
            ser1_irq_new = IRQ_4;
         end
      end
      ser2_irq_new = IRQ_NONE;
      if ((ser_ctrl_in & SER2_DIS_MASK) == 8'h00) begin
         if (ser_irq_in[7:6] == 2'b11) begin
            ser2_irq_new = IRQ_3;
         end else if (ser_irq_in[5:4] == 2'b11) begin
            ser2_irq_new = IRQ_4;
         end else if (ser_irq_in[1:0] == 2'b01) begin
            ser2_irq_new = IRQ_5;
         end
      end
   end

   // mapping next values
   always_comb begin
      lpt_en_in    = lpt_en_ff;
      lpt_base_in  = lpt_base_ff;
      com1_en_in   = com1_en_ff;
      com1_base_in = com1_base_ff;
      ser1_irq_in  = ser1_irq_ff;
      com2_en_in   = com2_en_ff;
      com2_base_in = com2_base_ff;
      ser2_irq_in  = ser2_irq_ff;
      if (lpt_trig) begin
         lpt_en_in   = ((lpt_ctrl_in & LPT_DIS_MASK) == 8'h00);
         lpt_base_in = lpt_en_in ? {lpt_basereg_in, 2'b00} : 10'h000;
      end
      if (com1_trig) begin
         com1_en_in   = (ser1_irq_new != IRQ_NONE);
         com1_base_in = com1_en_in ? {com1_basereg_in[7:1], 3'b000} : 10'h000;
         ser1_irq_in  = ser1_irq_new;
      end
      if (com2_trig) begin
         com2_en_in   = (ser2_irq_new != IRQ_NONE);
         com2_base_in = com2_en_in ? {com2_basereg_in[7:1], 3'b000} : 10'h000;
         ser2_irq_in  = ser2_irq_new;
      end
      floppy_in = floppy_ff;
      if (is_data_wr && (index_ff == REG_FDD_CTRL) && |(diff & FDD_DIS_BIT)) begin
         floppy_in = ((wdata_ff & FDD_DIS_BIT) == 8'h00);
      end
      ide_in = ide_ff;
      if (is_data_wr && (index_ff == REG_IDE_CTRL) && |(diff & IDE_DIS_BIT)) begin
         ide_in = ((wdata_ff & IDE_DIS_BIT) == 8'h00);
      end
   end

   // read data and index update
   always_comb begin
      index_in = index_ff;
      if ((mode_ff == MODE_WRITE) && (port_ff == PORT_INDEX)) begin
         index_in = wdata_ff;
      end
      if (mode_ff == MODE_WRITE) begin
         rsp_data_in = 8'h00;
      end else if (port_ff == PORT_INDEX) begin
         rsp_data_in = index_ff;
      end else if (index_ff < IDX_MIN_READABLE) begin
         rsp_data_in = READ_BLOCKED;
      end else begin
         rsp_data_in = old_byte;
      end
   end

   // sequencer next state and result valid
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (commit) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state, item latch, shadows, mappings and result register
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_bus.mode;
         port_ff  <= req_bus.port_select;
         wdata_ff <= req_bus.write_data;
      end
      if (commit) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         index_ff        <= 8'h00;
         lpt_ctrl_ff     <= 8'h00;
         lpt_basereg_ff  <= 8'h00;
         ser_ctrl_ff     <= 8'h00;
         com1_basereg_ff <= 8'h00;
         com2_basereg_ff <= 8'h00;
         ser_irq_ff      <= 8'h00;
         lpt_en_ff       <= 1'b1;
         lpt_base_ff     <= LPT_BASE_RESET;
         com1_en_ff      <= 1'b1;
         com1_base_ff    <= COM1_BASE_RESET;
         ser1_irq_ff     <= SER1_IRQ_RESET;
         com2_en_ff      <= 1'b1;
         com2_base_ff    <= COM2_BASE_RESET;
         ser2_irq_ff     <= SER2_IRQ_RESET;
         floppy_ff       <= 1'b1;
         ide_ff          <= 1'b1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            index_ff        <= index_in;
            lpt_ctrl_ff     <= lpt_ctrl_in;
            lpt_basereg_ff  <= lpt_basereg_in;
            ser_ctrl_ff     <= ser_ctrl_in;
            com1_basereg_ff <= com1_basereg_in;
            com2_basereg_ff <= com2_basereg_in;
            ser_irq_ff      <= ser_irq_in;
            lpt_en_ff       <= lpt_en_in;
            lpt_base_ff     <= lpt_base_in;
            com1_en_ff      <= com1_en_in;
            com1_base_ff    <= com1_base_in;
            ser1_irq_ff     <= ser1_irq_in;
            com2_en_ff      <= com2_en_in;
            com2_base_ff    <= com2_base_in;
            ser2_irq_ff     <= ser2_irq_in;
            floppy_ff       <= floppy_in;
            ide_ff          <= ide_in;
         end
      end
   end

   // result outputs; mappings only move when a new result loads
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.read_data      = rsp_data_ff;
   assign rsp_bus.lpt_enabled    = lpt_en_ff;
   assign rsp_bus.lpt_base       = lpt_base_ff;
   assign rsp_bus.com1_enabled   = com1_en_ff;
   assign rsp_bus.com1_base      = com1_base_ff;
   assign rsp_bus.ser1_irq       = ser1_irq_ff;
   assign rsp_bus.com2_enabled   = com2_en_ff;
   assign rsp_bus.com2_base      = com2_base_ff;
   assign rsp_bus.ser2_irq       = ser2_irq_ff;
   assign rsp_bus.floppy_enabled = floppy_ff;
   assign rsp_bus.ide_enabled    = ide_ff;

endmodule
